@@ hw/rtl/isbn10_pkg.sv @@
// ----------------------------------------------------------------------------
// isbn10_pkg
// Shared types, character codes and helpers for the hyphenated ISBN-10
// validator.
// ----------------------------------------------------------------------------
package isbn10_pkg;

	// Character codes.
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_X      = 8'd88;
	localparam logic [7:0] CH_HYPHEN = 8'd45;

	// Weighting, modulus and group length limits.
	localparam logic [3:0] START_WEIGHT = 4'd10;
	localparam logic [3:0] X_VALUE      = 4'd10;
	localparam logic [3:0] DIGITS_TOTAL = 4'd10;
	localparam logic [3:0] DIGITS_SAT   = 4'd15;
	localparam logic [6:0] MODULUS      = 7'd11;
	localparam logic [2:0] LIMIT_G0     = 3'd5;
	localparam logic [2:0] LIMIT_G1     = 3'd7;
	localparam logic [2:0] LIMIT_G2     = 3'd6;

	// Group codes.
	localparam logic [1:0] GROUP_FIRST  = 2'd0;
	localparam logic [1:0] GROUP_SECOND = 2'd1;
	localparam logic [1:0] GROUP_CHECK  = 2'd3;

	// Running state of one string.
	typedef struct packed {
		logic [1:0] group_index;
		logic [2:0] group_count;
		logic [3:0] total_digits;
		logic [3:0] weight;
		logic [3:0] sum_mod;
		logic       error_seen;
	} state_t;

	localparam state_t STATE_RST = '{
		group_index:  GROUP_FIRST,
		group_count:  3'd0,
		total_digits: 4'd0,
		weight:       START_WEIGHT,
		sum_mod:      4'd0,
		error_seen:   1'b0
	};

	// Remainder modulo 11 of a value below 128, by conditional subtraction
	// of 88, 44, 22 and 11.
	function automatic logic [3:0] mod11(input logic [6:0] x);
		logic [6:0] r;
		r = x;
		if (r >= (MODULUS << 3)) begin
			r = r - (MODULUS << 3);
		end
		if (r >= (MODULUS << 2)) begin
			r = r - (MODULUS << 2);
		end
		if (r >= (MODULUS << 1)) begin
			r = r - (MODULUS << 1);
		end
		if (r >= MODULUS) begin
			r = r - MODULUS;
		end
		return r[3:0];
	endfunction

endpackage

@@ hw/rtl/isbn10_update.sv @@
// ----------------------------------------------------------------------------
// isbn10_update
// Next-state logic for one character: group tracking, length checks and the
// weighted sum modulo 11, plus the final verdict on the updated state.
// ----------------------------------------------------------------------------
module isbn10_update (
	input  isbn10_pkg::state_t cur,
	input  logic [7:0]         ch,
	output isbn10_pkg::state_t nxt,
	output logic               ok
);

	logic       is_digit;
	logic       is_hyphen;
	logic       is_x;
	logic [2:0] limit;
	logic [3:0] value;
	logic [3:0] w;
	logic [7:0] prod;
	logic [6:0] acc;
	logic [3:0] new_sum;
	logic [3:0] new_total;

	// Character classes.
	assign is_digit  = (ch >= isbn10_pkg::CH_ZERO) && (ch <= isbn10_pkg::CH_NINE);
	assign is_hyphen = (ch == isbn10_pkg::CH_HYPHEN);
	assign is_x      = (ch == isbn10_pkg::CH_X);

	// Length limit of the current leading group.
	always_comb begin
		unique case (cur.group_index)
			isbn10_pkg::GROUP_FIRST:  limit = isbn10_pkg::LIMIT_G0;
			isbn10_pkg::GROUP_SECOND: limit = isbn10_pkg::LIMIT_G1;
			default:                  limit = isbn10_pkg::LIMIT_G2;
		endcase
	end

	// Digit value and weight; the check character has weight one.
	assign value = is_digit ? 4'(ch - isbn10_pkg::CH_ZERO) : isbn10_pkg::X_VALUE;
	assign w     = (cur.group_index == isbn10_pkg::GROUP_CHECK) ? 4'd1 : cur.weight;
	assign prod  = value * w;
	assign acc   = 7'(prod) + 7'(cur.sum_mod);
	assign new_sum = isbn10_pkg::mod11(acc);
	assign new_total = (cur.total_digits < isbn10_pkg::DIGITS_SAT) ?
		cur.total_digits + 4'd1 : cur.total_digits;

	// State update for one character.
	always_comb begin
		nxt = cur;
		if (!cur.error_seen) begin
			if (cur.group_index != isbn10_pkg::GROUP_CHECK) begin
				if (is_hyphen) begin
					if (cur.group_count == 3'd0) begin
						nxt.error_seen = 1'b1;
					end else begin
						nxt.group_index = cur.group_index + 2'd1;
						nxt.group_count = 3'd0;
					end
				end else if (is_digit) begin
					if ((cur.group_count >= limit) || (cur.weight <= 4'd1)) begin
						nxt.error_seen = 1'b1;
					end else begin
						nxt.sum_mod      = new_sum;
						nxt.total_digits = new_total;
						nxt.weight       = cur.weight - 4'd1;
						nxt.group_count  = cur.group_count + 3'd1;
					end
				end else begin
					nxt.error_seen = 1'b1;
				end
			end else begin
				if ((cur.group_count >= 3'd1) || !(is_digit || is_x)) begin
					nxt.error_seen = 1'b1;
				end else begin
					nxt.sum_mod      = new_sum;
					nxt.total_digits = new_total;
					nxt.group_count  = cur.group_count + 3'd1;
				end
			end
		end
	end

	// Verdict on the string if this character ends it.
	assign ok = !nxt.error_seen && (nxt.group_index == isbn10_pkg::GROUP_CHECK) &&
		(nxt.group_count == 3'd1) && (nxt.total_digits == isbn10_pkg::DIGITS_TOTAL) &&
		(nxt.sum_mod == 4'd0);

endmodule

@@ hw/rtl/isbn10_hyphenated_validator_unit.sv @@
// ----------------------------------------------------------------------------
// isbn10_hyphenated_validator_unit
// Checks a hyphenated ISBN-10 string arriving one character per request and
// returns one verdict per string on its last character.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------
//  input   | in_valid / in_ready  | ch[7:0], last
//  output  | out_valid / out_ready| valid_res
//
// One character per cycle is accepted unless a last character waits in the
// input register on a full verdict register; only a last character waits, so
// ordinary characters keep flowing while a verdict is held. A request is
// taken into the input register, and the running state is updated from it as
// it moves on; on a last character the verdict register loads together with
// that update, so out_valid rises as the last character leaves the input
// register. Reset clears the running state and both valid flags.
module isbn10_hyphenated_validator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       valid_res
);

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;
	isbn10_pkg::state_t state_q;
	isbn10_pkg::state_t state_nxt;
	logic               ok;
	logic               fire_s1;
	logic               out_valid_q;
	logic               valid_res_q;

	// The held character moves on unless it ends a string and the verdict
	// register is still occupied.
	assign fire_s1  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// Character update logic.
	isbn10_update u_update (
		.cur (state_q),
		.ch  (ch_s1),
		.nxt (state_nxt),
		.ok  (ok)
	);

	// Running state; a finished string returns to the start state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isbn10_pkg::STATE_RST;
		end else if (fire_s1) begin
			state_q <= last_s1 ? isbn10_pkg::STATE_RST : state_nxt;
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			valid_res_q <= ok;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;

endmodule
